@@ rtl/pressure_pad_retrigger_qualifier_defines.svh @@
// assertion macros for the pressure pad retrigger qualifier
// used by files that carry concurrent checks; needs clk and rst_n in scope
`ifndef PRESSURE_PAD_RETRIGGER_QUALIFIER_DEFINES_SVH
`define PRESSURE_PAD_RETRIGGER_QUALIFIER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PRR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prr check failed");

// antecedent implies consequent in the following cycle
`define PRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prr check failed");

`endif

@@ rtl/prr_pkg.sv @@
// shared types and constants of the pressure pad retrigger qualifier
// no dependencies
package prr_pkg;

    localparam int SENSORS        = 8;
    localparam int BUTTONS        = 8;
    localparam int HIST_DEPTH     = 12;
    localparam int SENS_W         = 3;
    localparam int SAMPLE_W       = 10;
    localparam int TOTAL_W        = 14;
    localparam int SLOT_W         = 4;
    localparam int HIST_ENTRIES   = SENSORS * HIST_DEPTH;
    localparam int ADDR_W         = $clog2(HIST_ENTRIES);
    localparam int BTN_CODE_W     = 4;
    localparam int MASK_W         = 8;
    localparam int THR_BANK_W     = 40;
    localparam int MAP_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 40;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 24;
    // total / 12 as (total * 10923) >> 17, exact for every 14-bit total
    localparam int MEAN_MULT      = 10923;
    localparam int MEAN_SHIFT     = 17;
    localparam int MEAN_MULT_W    = 14;
    localparam int PROD_W         = TOTAL_W + MEAN_MULT_W;
    localparam int ARM_WINDOW     = 30;
    localparam int RETRIGGER_JUMP = 50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_LOW    = 2'd0,
        CFG_THR_HIGH   = 2'd1,
        CFG_BUTTON_MAP = 2'd2
    } cfg_reg_t;

    typedef logic [BUTTONS-1:0] btn_mask_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic [SAMPLE_W-1:0]   smoothed;
        logic [SAMPLE_W-1:0]   hist_old;
        logic [TOTAL_W-1:0]    total;
        logic [SAMPLE_W-1:0]   thr;
        logic [BTN_CODE_W-1:0] btn;
        logic                  armed;
        btn_mask_t             decided;
    } eval_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [TOTAL_W-1:0]  total;
        logic                armed;
        logic                decide;
        logic                press;
        btn_mask_t           btn_bit;
    } eval_out_t;

    // flat history address: sensor * 12 + slot
    function automatic logic [ADDR_W-1:0] hist_addr(input logic [SENS_W-1:0] s,
                                                    input logic [SLOT_W-1:0] slot);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(s) * ADDR_W'(HIST_DEPTH) + ADDR_W'(slot);
        return a;
    endfunction

endpackage

@@ rtl/pressure_pad_retrigger_qualifier.sv @@
// top level of the pressure pad retrigger qualifier
// depends on prr_pkg, prr_hist, prr_eval and the assertion macro header
//
// One sample transfer enters per cycle while the output side is ready, and one result transfer
// leaves per sample from the result register. The input register stage also issues the
// history read; the evaluation logic (half-sum smoothing, 12-entry running history sum, mean by
// reciprocal multiply, arm/release decision) sits between that stage and the result register.
// Per-sensor levels, sums and arm flags are flip-flops read at the sample's sensor; the 96-entry
// history is a memory with per-entry valid bits, so it needs no clearing pass after reset. A
// write to the history that coincides with a read of the same entry is forwarded. While a
// result waits, the input stage still takes one sample if it is empty and then stalls;
// s_tready follows m_tready combinationally through the stage drain.
// Configuration writes are meant for idle periods only.
module pressure_pad_retrigger_qualifier (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prr_pkg::IN_DATA_W-1:0]   s_tdata,   // sensor_index[2:0], sample[12:3], zero pad
    input  logic                            s_tlast,   // frame_end
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prr_pkg::OUT_DATA_W-1:0]  m_tdata,   // sensor_echo[2:0], filtered_level[12:3],
                                                       // buttons_pressed[20:13], zero pad
    output logic                            m_tlast,   // frame_done
    // configuration
    input  logic                            cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import prr_pkg::*;

    `include "pressure_pad_retrigger_qualifier_defines.svh"

    // configuration registers
    logic [THR_BANK_W-1:0] thr_low_reg;
    logic [THR_BANK_W-1:0] thr_high_reg;
    logic [MAP_W-1:0]      map_reg;

    // per-sensor state
    logic [SAMPLE_W-1:0] smoothed_reg [SENSORS];
    logic [TOTAL_W-1:0]  total_reg    [SENSORS];
    logic [SENSORS-1:0]  armed_reg;

    // frame state
    logic [SLOT_W-1:0] slot_reg;
    btn_mask_t         decided_reg;
    btn_mask_t         building_reg;
    logic [MASK_W-1:0] reported_reg;

    // input stage
    logic                stg_vld_reg;
    logic [SENS_W-1:0]   stg_s_reg;
    logic [SAMPLE_W-1:0] stg_sample_reg;
    logic                stg_last_reg;
    logic [ADDR_W-1:0]   stg_addr_reg;

    // result register
    logic                out_vld_reg;
    logic [SENS_W-1:0]   out_s_reg;
    logic [SAMPLE_W-1:0] out_level_reg;
    logic [MASK_W-1:0]   out_btn_reg;
    logic                out_last_reg;

    logic                in_xfer;
    logic                stg_adv;
    logic [SENS_W-1:0]   in_s;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] hist_old;
    logic                sens_ok;
    logic                hist_we;
    logic [SAMPLE_W-1:0] thr_sel;
    logic [SLOT_W-1:0]   slot_next;
    btn_mask_t           decided_next;
    btn_mask_t           building_next;
    logic [MASK_W-1:0]   reported_next;
    eval_in_t            ein;
    eval_out_t           eout;

    // handshake: the input stage drains into the result register when it is empty or its result is taken
    assign stg_adv  = stg_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !stg_vld_reg || stg_adv;
    assign in_xfer  = s_tvalid && s_tready;

    assign in_s    = s_tdata[SENS_W-1:0];
    assign rd_addr = hist_addr(in_s, slot_reg);

    // slot advances at the transfer of a frame end; each sample carries its own address
    assign slot_next = (slot_reg == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (in_xfer && s_tlast)
        begin
            slot_reg <= slot_next;
        end
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg  <= '0;
            thr_high_reg <= '0;
            map_reg      <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR_LOW:    thr_low_reg  <= cfg_wdata[THR_BANK_W-1:0];
                CFG_THR_HIGH:   thr_high_reg <= cfg_wdata[THR_BANK_W-1:0];
                CFG_BUTTON_MAP: map_reg      <= cfg_wdata[MAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            stg_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_s_reg      <= in_s;
            stg_sample_reg <= s_tdata[SENS_W +: SAMPLE_W];
            stg_last_reg   <= s_tlast;
            stg_addr_reg   <= rd_addr;
        end
    end

    // history memory, write-back from the sample leaving the input stage
    assign sens_ok = {1'b0, stg_s_reg} < (SENS_W+1)'(SENSORS);
    assign hist_we = stg_adv && sens_ok;

    prr_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (rd_addr),
        .wr_en   (hist_we),
        .wr_addr (stg_addr_reg),
        .wr_data (eout.level),
        .rd_data (hist_old)
    );

    // sensor threshold: four per bank, ten bits each
    assign thr_sel = stg_s_reg[2] ? thr_high_reg[stg_s_reg[1:0] * SAMPLE_W +: SAMPLE_W]
                                  : thr_low_reg[stg_s_reg[1:0] * SAMPLE_W +: SAMPLE_W];

    always_comb
    begin
        ein.sample   = stg_sample_reg;
        ein.smoothed = smoothed_reg[stg_s_reg];
        ein.hist_old = hist_old;
        ein.total    = total_reg[stg_s_reg];
        ein.thr      = thr_sel;
        ein.btn      = map_reg[{stg_s_reg, 2'b00} +: BTN_CODE_W];
        ein.armed    = armed_reg[stg_s_reg];
        ein.decided  = decided_reg;
    end

    prr_eval u_eval (
        .ein  (ein),
        .eout (eout)
    );

    // frame masks: decided/building gather per frame, reported latches at frame end
    always_comb
    begin
        decided_next  = decided_reg;
        building_next = building_reg;
        reported_next = reported_reg;
        if (sens_ok && eout.decide)
        begin
            decided_next = decided_reg | eout.btn_bit;
        end
        if (sens_ok && eout.press)
        begin
            building_next = building_reg | eout.btn_bit;
        end
        if (stg_last_reg)
        begin
            reported_next = MASK_W'(building_next);
            decided_next  = '0;
            building_next = '0;
        end
    end

    // state update when a sample leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                smoothed_reg[i] <= '0;
                total_reg[i]    <= '0;
            end
            armed_reg    <= '0;
            decided_reg  <= '0;
            building_reg <= '0;
            reported_reg <= '0;
        end
        else if (stg_adv)
        begin
            if (sens_ok)
            begin
                smoothed_reg[stg_s_reg] <= eout.level;
                total_reg[stg_s_reg]    <= eout.total;
                armed_reg[stg_s_reg]    <= eout.armed;
            end
            decided_reg  <= decided_next;
            building_reg <= building_next;
            reported_reg <= reported_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (stg_adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            out_s_reg     <= stg_s_reg;
            out_level_reg <= sens_ok ? eout.level : '0;
            out_btn_reg   <= reported_next;
            out_last_reg  <= stg_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_DATA_W - SENS_W - SAMPLE_W - MASK_W)'(0),
                       out_btn_reg, out_level_reg, out_s_reg};

    // checks
    `PRR_ASSERT_SAME(a_slot_range, 1'b1, slot_reg <= SLOT_W'(HIST_DEPTH - 1))
    `PRR_ASSERT_SAME(a_building_in_decided, 1'b1, (building_reg & ~decided_reg) == '0)
    `PRR_ASSERT_NEXT(a_frame_clears, stg_adv && stg_last_reg, decided_reg == '0)
    `PRR_ASSERT_NEXT(a_report_holds, !(stg_adv && stg_last_reg), $stable(reported_reg))

endmodule

@@ rtl/prr_hist.sv @@
// per-sensor level history store, one read and one write port
// depends on prr_pkg; unwritten entries read as zero through valid bits
module prr_hist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [prr_pkg::ADDR_W-1:0]   rd_addr,
    input  logic                         wr_en,
    input  logic [prr_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [prr_pkg::SAMPLE_W-1:0] wr_data,
    output logic [prr_pkg::SAMPLE_W-1:0] rd_data
);
    import prr_pkg::*;

    logic [SAMPLE_W-1:0]     mem [HIST_ENTRIES];
    logic [HIST_ENTRIES-1:0] vld_reg;
    logic [SAMPLE_W-1:0]     rd_q_reg;
    logic                    rdv_q_reg;
    logic                    bypass;

    // a write landing in the same cycle as the read of the same entry
    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= bypass ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rdv_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rdv_q_reg <= bypass || vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rdv_q_reg ? rd_q_reg : '0;

endmodule

@@ rtl/prr_eval.sv @@
// per-sample smoothing, history sum update and button decision
// depends on prr_pkg; purely combinational
module prr_eval (
    input  prr_pkg::eval_in_t  ein,
    output prr_pkg::eval_out_t eout
);
    import prr_pkg::*;

    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] level;
    logic [TOTAL_W-1:0]  total_new;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] mean;
    logic                armed0;
    logic                near;
    logic                jump;
    logic                btn_ok;
    btn_mask_t           btn_bit;
    logic                decide;
    logic                release_hit;

    always_comb
    begin
        sum       = {1'b0, ein.smoothed} + {1'b0, ein.sample};
        level     = sum[SAMPLE_W:1];
        total_new = ein.total - TOTAL_W'(ein.hist_old) + TOTAL_W'(level);
        prod      = PROD_W'(total_new) * PROD_W'(MEAN_MULT);
        mean      = prod[MEAN_SHIFT +: SAMPLE_W];

        armed0 = ein.armed && !(level < ein.thr);
        near   = {1'b0, level} < ({1'b0, mean} + (SAMPLE_W+1)'(ARM_WINDOW));
        jump   = {1'b0, level} > ({1'b0, mean} + (SAMPLE_W+1)'(RETRIGGER_JUMP));

        btn_ok  = ein.btn < BTN_CODE_W'(BUTTONS);
        btn_bit = btn_ok ? (btn_mask_t'(1) << ein.btn) : '0;
        decide  = btn_ok && ((ein.decided & btn_bit) == '0) && (level > ein.thr);

        // arming happens first, then a big jump over the mean releases
        release_hit = (armed0 || near) && jump;

        eout.level   = level;
        eout.total   = total_new;
        eout.armed   = decide ? ((armed0 || near) && !jump) : armed0;
        eout.decide  = decide;
        eout.press   = decide && !release_hit;
        eout.btn_bit = btn_bit;
    end

endmodule

@@ sim/pressure_pad_retrigger_qualifier_test.sv @@
// self-checking bench for the pressure pad retrigger qualifier: directed script, then random frames
// predicts every result transfer with its own copy of the filter, history and button state
// depends on prr_pkg and the pressure_pad_retrigger_qualifier top level
`timescale 1ns / 1ps

module pressure_pad_retrigger_qualifier_test;
    import prr_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    // two register stages inside the block, with some margin
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 490;
    localparam int REPORT_MAX    = 10;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // one line of the directed script
    typedef struct {
        row_kind_t             kind;
        logic [SENS_W-1:0]     sensor;
        logic [SAMPLE_W-1:0]   raw;
        logic                  last;
        cfg_reg_t              reg_index;
        logic [CFG_DATA_W-1:0] value;
        bit                    fixed;
        logic [SAMPLE_W-1:0]   want_level;
        logic [MASK_W-1:0]     want_buttons;
    } script_row_t;

    typedef struct packed {
        logic [SENS_W-1:0]   sensor;
        logic [SAMPLE_W-1:0] level;
        logic [MASK_W-1:0]   buttons;
        logic                done;
    } pad_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // bench copy of the configuration registers
    logic [THR_BANK_W-1:0] thr_low_bank  = '0;
    logic [THR_BANK_W-1:0] thr_high_bank = '0;
    logic [MAP_W-1:0]      map_word      = '1;

    // bench copy of the per-sensor and per-frame state
    logic [SAMPLE_W-1:0] pad_level   [SENSORS];
    logic [SAMPLE_W-1:0] pad_history [SENSORS][HIST_DEPTH];
    logic [TOTAL_W-1:0]  pad_total   [SENSORS];
    logic                pad_armed   [SENSORS];
    int unsigned         frame_slot  = 0;
    logic [BUTTONS-1:0]  decided_mask  = '0;
    logic [BUTTONS-1:0]  building_mask = '0;
    logic [MASK_W-1:0]   reported_mask = '0;

    pad_result_t pending_results [$];
    logic [SAMPLE_W-1:0] raw_hold [SENSORS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int phase_sent     = 0;
    int quiet_cycles   = 0;

    script_row_t script [27];

    pressure_pad_retrigger_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sensor_index[2:0], sample[12:3], zero pad
        .s_tlast   (s_tlast),   // frame_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // sensor_echo[2:0], filtered_level[12:3], buttons_pressed[20:13]
        .m_tlast   (m_tlast),   // frame_done
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: smoothing, running history sum, arm / release decision
    // ------------------------------------------------------------------
    task automatic qualify_sample(input logic [SENS_W-1:0] s, input logic [SAMPLE_W-1:0] raw,
                                  input logic last, output pad_result_t res);
        logic [SAMPLE_W:0]     sum;
        logic [SAMPLE_W-1:0]   level;
        logic [SAMPLE_W-1:0]   thr;
        logic [BTN_CODE_W-1:0] btn;
        int unsigned           mean;
        int unsigned           slot;
        slot = (frame_slot < HIST_DEPTH) ? frame_slot : 0;
        thr = (s < 4) ? thr_low_bank[10*s +: 10] : thr_high_bank[10*(s-4) +: 10];
        btn = map_word[4*s +: 4];
        sum = {1'b0, pad_level[s]} + {1'b0, raw};
        level = sum[SAMPLE_W:1];
        pad_level[s] = level;
        // 14-bit running sum, oldest entry of this slot drops out
        pad_total[s] = pad_total[s] - TOTAL_W'(pad_history[s][slot]) + TOTAL_W'(level);
        pad_history[s][slot] = level;
        if (level < thr)
            pad_armed[s] = 1'b0;
        mean = int'(pad_total[s]) / HIST_DEPTH;
        // first mapped sensor above threshold decides the button for this frame
        if (btn < BUTTONS && !decided_mask[btn[2:0]] && level > thr) begin
            decided_mask[btn[2:0]] = 1'b1;
            if (!pad_armed[s] && int'(level) < mean + ARM_WINDOW)
                pad_armed[s] = 1'b1;
            if (pad_armed[s] && int'(level) > mean + RETRIGGER_JUMP)
                pad_armed[s] = 1'b0;
            else
                building_mask[btn[2:0]] = 1'b1;
        end
        if (last) begin
            reported_mask = MASK_W'(building_mask);
            decided_mask  = '0;
            building_mask = '0;
            frame_slot    = (slot + 1) % HIST_DEPTH;
        end
        res.sensor  = s;
        res.level   = level;
        res.buttons = reported_mask;
        res.done    = last;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // valid drops only while a gap is taken or the sender settles, so it is
    // never lowered and raised in the same step
    task automatic send_sample(input logic [SENS_W-1:0] s, input logic [SAMPLE_W-1:0] raw,
                               input logic last, input bit fixed,
                               input logic [SAMPLE_W-1:0] want_level,
                               input logic [MASK_W-1:0] want_buttons);
        pad_result_t res;
        if (!s_tvalid)
            s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({raw, s});
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // transfer taken at this edge
        qualify_sample(s, raw, last, res);
        if (fixed) begin
            res.level   = want_level;
            res.buttons = want_buttons;
        end
        pending_results.push_back(res);
        phase_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // hold off the sender until every result transfer is back
    task automatic settle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THR_LOW:    thr_low_bank  = value[THR_BANK_W-1:0];
            CFG_THR_HIGH:   thr_high_bank = value[THR_BANK_W-1:0];
            CFG_BUTTON_MAP: map_word      = value[MAP_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------
    // pad pressure mostly drifts, sometimes jumps or slams to a rail
    function automatic logic [SAMPLE_W-1:0] next_raw(input int s);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 70) begin
            v = int'(raw_hold[s]) + $urandom_range(80) - 40;
            v = (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
        end else if (pick < 85) begin
            v = $urandom_range(1023);
        end else begin
            v = $urandom_range(1) ? 1023 : 0;
        end
        raw_hold[s] = SAMPLE_W'(v);
        return raw_hold[s];
    endfunction

    function automatic logic [THR_BANK_W-1:0] rand_bank(input int top);
        logic [THR_BANK_W-1:0] bank;
        for (int i = 0; i < 4; i++)
            bank[10*i +: 10] = SAMPLE_W'($urandom_range(top));
        return bank;
    endfunction

    task automatic send_frame();
        logic [SENSORS-1:0] present;
        int top;
        int count;
        if ($urandom_range(99) < 85) begin
            // well-formed frame: ascending sensors, last one flagged
            present = SENSORS'($urandom_range(255, 1));
            top = 0;
            for (int s = 0; s < SENSORS; s++)
                if (present[s])
                    top = s;
            for (int s = 0; s < SENSORS; s++)
                if (present[s])
                    send_sample(SENS_W'(s), next_raw(s), s == top, 1'b0, '0, '0);
        end else begin
            // noise: random order, repeats, stray or missing frame ends
            count = $urandom_range(4, 1);
            for (int i = 0; i < count; i++) begin
                top = $urandom_range(SENSORS - 1);
                send_sample(SENS_W'(top), next_raw(top), 1'($urandom_range(1)),
                            1'b0, '0, '0);
            end
        end
    endtask

    task automatic configure_phase(input int phase);
        logic [MAP_W-1:0] map;
        case (phase)
            0: begin
                write_reg(CFG_THR_LOW, rand_bank(400));
                write_reg(CFG_THR_HIGH, rand_bank(400));
                write_reg(CFG_BUTTON_MAP, CFG_DATA_W'(32'h7654_3210));
            end
            1: begin
                write_reg(CFG_THR_LOW, '0);
                write_reg(CFG_THR_HIGH, {THR_BANK_W{1'b1}});
                write_reg(CFG_BUTTON_MAP, CFG_DATA_W'($urandom));
            end
            2: begin
                write_reg(CFG_THR_LOW, CFG_DATA_W'({$urandom, $urandom}));
                write_reg(CFG_THR_HIGH, CFG_DATA_W'({$urandom, $urandom}));
                // small codes so that several sensors share a button
                for (int i = 0; i < SENSORS; i++)
                    map[4*i +: 4] = BTN_CODE_W'($urandom_range(9));
                write_reg(CFG_BUTTON_MAP, CFG_DATA_W'(map));
            end
            default: begin
                write_reg(CFG_THR_LOW, {THR_BANK_W{1'b1}});
                write_reg(CFG_THR_HIGH, rand_bank(200));
                write_reg(CFG_BUTTON_MAP, '0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls, checks against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        pad_result_t want;
        pad_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.sensor  = m_tdata[2:0];
            got.level   = m_tdata[12:3];
            got.buttons = m_tdata[20:13];
            got.done    = m_tlast;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result transfer with nothing pending: %p", got));
            end else begin
                want = pending_results.pop_front();
                if (got.sensor !== want.sensor || got.level !== want.level ||
                    got.buttons !== want.buttons || got.done !== want.done)
                    note_failure($sformatf(
                        "mismatch sensor %0d/%0d level %0d/%0d buttons %h/%h done %0d/%0d",
                        want.sensor, got.sensor, want.level, got.level,
                        want.buttons, got.buttons, want.done, got.done));
            end
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic script_row_t smp(input int s, input int raw, input bit last);
        script_row_t r;
        r = '{kind: ROW_SAMPLE, sensor: SENS_W'(s), raw: SAMPLE_W'(raw), last: last,
              reg_index: CFG_THR_LOW, value: '0, fixed: 1'b0, want_level: '0, want_buttons: '0};
        return r;
    endfunction

    function automatic script_row_t smp_fixed(input int s, input int raw, input bit last,
                                              input int level, input int buttons);
        script_row_t r;
        r = smp(s, raw, last);
        r.fixed        = 1'b1;
        r.want_level   = SAMPLE_W'(level);
        r.want_buttons = MASK_W'(buttons);
        return r;
    endfunction

    function automatic script_row_t wr(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        script_row_t r;
        r = smp(0, 0, 1'b0);
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.value     = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int s = 0; s < SENSORS; s++) begin
            pad_level[s] = '0;
            pad_total[s] = '0;
            pad_armed[s] = 1'b0;
            raw_hold[s]  = SAMPLE_W'($urandom_range(1023));
            for (int k = 0; k < HIST_DEPTH; k++)
                pad_history[s][k] = '0;
        end

        script = '{
            // straight out of reset: no thresholds, every sensor unassigned
            smp_fixed(0, 1023, 1'b0, 511, 0),
            smp_fixed(7, 0, 1'b1, 0, 0),
            // frame of one unmapped sample, back-to-back frame ends
            smp_fixed(3, 1023, 1'b1, 511, 0),
            wr(CFG_BUTTON_MAP, CFG_DATA_W'(32'h7654_3210)),
            wr(CFG_THR_LOW, {4{10'd100}}),
            wr(CFG_THR_HIGH, {10'd1023, 10'd0, 10'd500, 10'd50}),
            smp(0, 300, 1'b0),
            smp(1, 20, 1'b0),          // below threshold, disarms
            smp(4, 1023, 1'b0),
            smp(7, 1023, 1'b1),        // threshold at the rail, never above
            smp(6, 20, 1'b1),          // near the mean: arms and presses
            smp(6, 1023, 1'b1),        // big jump while armed: release
            smp(6, 1023, 1'b1),        // disarmed now, pressed again
            smp(5, 1023, 1'b0),
            smp(4, 0, 1'b0),           // out of order
            smp(4, 1023, 1'b0),        // repeated sensor in the same frame
            smp(6, 0, 1'b1),
            // shared button, unassigned codes, button code above the mask
            wr(CFG_BUTTON_MAP, CFG_DATA_W'(32'h3877_F900)),
            smp(0, 1023, 1'b0),
            smp(1, 1023, 1'b0),
            smp(2, 1023, 1'b0),
            smp(3, 1023, 1'b0),
            smp(7, 512, 1'b1),
            wr(CFG_THR_LOW, {CFG_DATA_W{1'b1}}),
            wr(CFG_THR_HIGH, {CFG_DATA_W{1'b1}}),
            smp(0, 1023, 1'b1),
            smp(5, 0, 1'b1)
        };

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on either side
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].reg_index, script[i].value);
            else
                send_sample(script[i].sensor, script[i].raw, script[i].last,
                            script[i].fixed, script[i].want_level, script[i].want_buttons);
        end

        // random part: four phases, each with its own configuration and idling settings
        for (int phase = 0; phase < 4; phase++) begin
            int pause_at;
            bit paused;
            configure_phase(phase);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            phase_sent = 0;
            paused = 1'b0;
            pause_at = $urandom_range(PHASE_ITEMS - 50, 50);
            while (phase_sent < PHASE_ITEMS) begin
                // sender waits for the pipeline to empty once per phase
                if (!paused && phase_sent >= pause_at) begin
                    settle();
                    paused = 1'b1;
                end
                send_frame();
            end
        end

        settle();
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            note_failure("prediction left without a result transfer");
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/prr_pkg.sv
rtl/prr_hist.sv
rtl/prr_eval.sv
rtl/pressure_pad_retrigger_qualifier.sv
sim/pressure_pad_retrigger_qualifier_test.sv
